### hw/rtl/mrx_pkg.sv
// Shared types, constants and the log10 table for the retinex pixel combiner.
package mrx_pkg;

   localparam int unsigned PIX_W      = 8;
   localparam int unsigned LOG_W      = 16;
   localparam int unsigned RATIO_W    = 16;
   localparam int unsigned SUM_W      = 18;
   localparam int unsigned GAIN_W     = 10;
   localparam int unsigned PROD_W     = SUM_W + GAIN_W;
   localparam int unsigned RATIO_FRAC = 12;
   localparam int unsigned RECIP_W    = 17;
   localparam int unsigned SCALED_W   = PROD_W - RATIO_FRAC;
   localparam int unsigned REC_PROD_W = SCALED_W + RECIP_W;
   // floor(x / 3) == (x * 43691) >> 17 for every 16-bit x
   localparam logic [RECIP_W-1:0] RECIP_3 = 17'd43691;
   localparam logic [GAIN_W-1:0]  GAIN_RESET = 10'd210;
   localparam logic [PIX_W-1:0]   OUT_MAX = 8'd255;
   localparam logic [RATIO_W-1:0] RATIO_MAX = 16'hFFFF;
   localparam int unsigned NUM_SCALES = 3;
   localparam int unsigned NUM_CHANS  = 3;
   localparam int unsigned DIV_STAGES = RATIO_W + 1;
   // ROM stage, divider, sum, gain product, reciprocal product, clamp
   localparam int unsigned PIPE_DEPTH = 1 + DIV_STAGES + 4;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_ADDR = 3'd0;

   typedef logic [LOG_W-1:0] rom_type [256];

   // log10(k) in Q3.13 through a 20-step squaring log2, zero at k == 0
   function automatic logic [LOG_W-1:0] rom_entry(input int unsigned k);
      int unsigned n;
      longint unsigned m;
      longint unsigned frac;
      longint unsigned l2;
      longint unsigned prod;
      n = 0;
      frac = 0;
      if (k == 0) begin
         return '0;
      end
      for (int i = 1; i < 8; i++) begin
         if ((k >> i) != 0) n = i;
      end
      m = longint'(k) << (30 - n);
      for (int i = 0; i < 20; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      l2 = (longint'(n) << 20) | frac;
      prod = (l2 * 64'd1292913986 + (64'd1 << 38)) >> 39;
      return prod[LOG_W-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < 256; k++) begin
         r[k] = rom_entry(k);
      end
      return r;
   endfunction

   localparam rom_type LOG_ROM = build_rom();

endpackage

### hw/rtl/mrx_if.sv
// Valid/ready channel interfaces for pixel requests and enhanced results.
interface mrx_req_if;
   import mrx_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pix_blue;
   logic [PIX_W-1:0] pix_green;
   logic [PIX_W-1:0] pix_red;
   logic [PIX_W-1:0] blur_wide_blue;
   logic [PIX_W-1:0] blur_wide_green;
   logic [PIX_W-1:0] blur_wide_red;
   logic [PIX_W-1:0] blur_narrow_blue;
   logic [PIX_W-1:0] blur_narrow_green;
   logic [PIX_W-1:0] blur_narrow_red;
   logic [PIX_W-1:0] blur_mid_blue;
   logic [PIX_W-1:0] blur_mid_green;
   logic [PIX_W-1:0] blur_mid_red;
   modport source (output valid, pix_blue, pix_green, pix_red,
                   blur_wide_blue, blur_wide_green, blur_wide_red,
                   blur_narrow_blue, blur_narrow_green, blur_narrow_red,
                   blur_mid_blue, blur_mid_green, blur_mid_red,
                   input ready);
   modport sink (input valid, pix_blue, pix_green, pix_red,
                 blur_wide_blue, blur_wide_green, blur_wide_red,
                 blur_narrow_blue, blur_narrow_green, blur_narrow_red,
                 blur_mid_blue, blur_mid_green, blur_mid_red,
                 output ready);
endinterface

interface mrx_rsp_if;
   import mrx_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_blue;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_red;
   modport source (output valid, out_blue, out_green, out_red, input ready);
   modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface

### hw/rtl/mrx_div.sv
// Pipelined restoring divider: Q4.12 ratio of two logs, one quotient bit per stage.
module mrx_div
   import mrx_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [LOG_W-1:0]   num,
   input  logic [LOG_W-1:0]   den,
   output logic [RATIO_W-1:0] ratio
);

   logic [LOG_W-1:0]   rem_ff  [DIV_STAGES];
   logic [RATIO_W-1:0] quo_ff  [DIV_STAGES];
   logic [RATIO_W-1:0] low_ff  [DIV_STAGES];
   logic [LOG_W-1:0]   den_ff  [DIV_STAGES];
   logic               ovr_ff  [DIV_STAGES];
   logic               ovz_ff  [DIV_STAGES];

   logic               ovr_in;
   logic               ovz_in;
   logic [LOG_W+3:0]   den_x16;

   // flag zero denominators and quotients that would not fit
   always_comb begin
      den_x16 = {den, 4'b0};
      ovr_in = 1'b0;
      ovz_in = 1'b0;
      if (den == '0) begin
         ovr_in = 1'b1;
         ovz_in = (num == '0);
      end else if ({4'b0, num} >= den_x16) begin
         ovr_in = 1'b1;
      end
   end

   // load the first stage: high dividend bits start the remainder
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {4'b0, num[LOG_W-1:4]};
         low_ff[0] <= {num[3:0], {RATIO_FRAC{1'b0}}};
         quo_ff[0] <= '0;
         den_ff[0] <= den;
         ovr_ff[0] <= ovr_in;
         ovz_ff[0] <= ovz_in;
      end
   end

   // one compare and subtract per stage
   for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
      logic [LOG_W:0] trial;
      logic           ge;
      assign trial = {rem_ff[s-1], low_ff[s-1][RATIO_W-1]};
      assign ge    = (trial >= {1'b0, den_ff[s-1]});
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? LOG_W'(trial - {1'b0, den_ff[s-1]}) : trial[LOG_W-1:0];
            quo_ff[s] <= {quo_ff[s-1][RATIO_W-2:0], ge};
            low_ff[s] <= {low_ff[s-1][RATIO_W-2:0], 1'b0};
            den_ff[s] <= den_ff[s-1];
            ovr_ff[s] <= ovr_ff[s-1];
            ovz_ff[s] <= ovz_ff[s-1];
         end
      end
   end

   assign ratio = ovr_ff[DIV_STAGES-1] ? (ovz_ff[DIV_STAGES-1] ? '0 : RATIO_MAX)
                                       : quo_ff[DIV_STAGES-1];

endmodule

### hw/rtl/mrx_lane.sv
// One color channel: log lookup, three ratios, average, gain and clamp.
module mrx_lane
   import mrx_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [GAIN_W-1:0] gain,
   input  logic [PIX_W-1:0]  pix,
   input  logic [PIX_W-1:0]  blur_wide,
   input  logic [PIX_W-1:0]  blur_narrow,
   input  logic [PIX_W-1:0]  blur_mid,
   output logic [PIX_W-1:0]  result
);

   logic [LOG_W-1:0]      num_ff;
   logic [LOG_W-1:0]      den_ff [NUM_SCALES];
   logic [RATIO_W-1:0]    ratio  [NUM_SCALES];
   logic [SUM_W-1:0]      sum_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [REC_PROD_W-1:0] rec_ff;
   logic [PIX_W-1:0]      result_ff;
   logic [SCALED_W-1:0]   quot;

   // look up the logs of the pixel and its blurred values
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff    <= LOG_ROM[pix];
         den_ff[0] <= LOG_ROM[blur_wide];
         den_ff[1] <= LOG_ROM[blur_narrow];
         den_ff[2] <= LOG_ROM[blur_mid];
      end
   end

   for (genvar s = 0; s < NUM_SCALES; s++) begin : g_div
      mrx_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num_ff),
         .den   (den_ff[s]),
         .ratio (ratio[s])
      );
   end

   assign quot = rec_ff[REC_PROD_W-1:RECIP_W];

   // sum ratios, apply gain, divide by 3 * 4096, clamp
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff    <= SUM_W'(ratio[0]) + SUM_W'(ratio[1]) + SUM_W'(ratio[2]);
         prod_ff   <= PROD_W'(sum_ff) * PROD_W'(gain);
         rec_ff    <= REC_PROD_W'(prod_ff[PROD_W-1:RATIO_FRAC]) * REC_PROD_W'(RECIP_3);
         result_ff <= (quot > SCALED_W'(OUT_MAX)) ? OUT_MAX : quot[PIX_W-1:0];
      end
   end

   assign result = result_ff;

endmodule

### hw/rtl/multiscale_retinex_pixel_combine_core.sv
// Top level: channel lanes, stall control, output valid and gain register.
// Pipeline: 22 register stages lie between an input transfer and its valid result.
// Throughput: one pixel per cycle; the whole pipeline holds while a result waits.
// Each lane runs three 17-stage dividers: a load stage, then one quotient bit per stage.
// Reset (synchronous, active high) clears all stage valids and sets gain to 210.
// The log table is a constant and needs no fill after reset.
module multiscale_retinex_pixel_combine_core
   import mrx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mrx_req_if.sink               req_if,
   mrx_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [GAIN_W-1:0]     gain_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;
   logic                  adv;
   logic                  csr_wr;
   logic                  csr_gain_sel;

   // advance unless a finished result is stalled
   assign adv = !vld_ff[PIPE_DEPTH-1] || rsp_if.ready;
   assign req_if.ready = adv;

   always_comb begin
      vld_in = vld_ff;
      if (adv) vld_in = {vld_ff[PIPE_DEPTH-2:0], req_if.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   mrx_lane u_lane_blue (
      .clock (clock), .en (adv), .gain (gain_ff),
      .pix (req_if.pix_blue), .blur_wide (req_if.blur_wide_blue),
      .blur_narrow (req_if.blur_narrow_blue), .blur_mid (req_if.blur_mid_blue),
      .result (rsp_if.out_blue)
   );

   mrx_lane u_lane_green (
      .clock (clock), .en (adv), .gain (gain_ff),
      .pix (req_if.pix_green), .blur_wide (req_if.blur_wide_green),
      .blur_narrow (req_if.blur_narrow_green), .blur_mid (req_if.blur_mid_green),
      .result (rsp_if.out_green)
   );

   mrx_lane u_lane_red (
      .clock (clock), .en (adv), .gain (gain_ff),
      .pix (req_if.pix_red), .blur_wide (req_if.blur_wide_red),
      .blur_narrow (req_if.blur_narrow_red), .blur_mid (req_if.blur_mid_red),
      .result (rsp_if.out_red)
   );

   assign rsp_if.valid = vld_ff[PIPE_DEPTH-1];

   // gain register write and readback, decoded on the word index
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_gain_sel = (csr_paddr[CSR_ADDR_W-1:2] == CSR_GAIN_ADDR[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_wr && csr_gain_sel) begin
         gain_ff <= csr_pwdata[GAIN_W-1:0];
      end
   end

   assign csr_prdata = csr_gain_sel ? {22'b0, gain_ff} : 32'b0;

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !req_if.ready)
      else $error("input taken while result stalled");

   a_enter_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> vld_ff[0])
      else $error("accepted transfer lost at pipe entry");

   a_gain_reset: assert property (@(posedge clock)
      reset |=> (gain_ff == GAIN_RESET))
      else $error("gain not restored by reset");

endmodule
